### sv/cpcf_pkg.sv
// ----------------------------------------------------------------------------
// cpcf_pkg
// shared types and constants of the cross peak clamp filter
// ----------------------------------------------------------------------------
`default_nettype none

package cpcf_pkg;

    localparam int PIX_W       = 16;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 16;
    localparam int MAX_WIDTH   = 1024;
    localparam int WIDTH_REG_W = 11;
    localparam int MEM_AW      = COL_W + 1;
    localparam int MEM_DEPTH   = 2 * MAX_WIDTH;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    // neighbor positions inside the has mask
    localparam int NB_UP    = 0;
    localparam int NB_DOWN  = 1;
    localparam int NB_LEFT  = 2;
    localparam int NB_RIGHT = 3;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix       me;
        t_pix       up;
        t_pix       down;
        t_pix       left;
        t_pix       right;
        logic [3:0] has;
    } t_window;

endpackage

`default_nettype wire

### sv/cpcf_line_mem.sv
// ----------------------------------------------------------------------------
// cpcf_line_mem
// two-row line store, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module cpcf_line_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [cpcf_pkg::MEM_AW-1:0] i_addr_a,
    input  wire cpcf_pkg::t_pix            i_wdata,
    input  wire logic [cpcf_pkg::MEM_AW-1:0] i_addr_b,
    output cpcf_pkg::t_pix                 o_rdata_a,
    output cpcf_pkg::t_pix                 o_rdata_b
);

    cpcf_pkg::t_pix r_mem [cpcf_pkg::MEM_DEPTH];
    cpcf_pkg::t_pix r_rdata_a;
    cpcf_pkg::t_pix r_rdata_b;

    // port a reads the old entry and writes the new one in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata_a       <= r_mem[i_addr_a];
            r_rdata_b       <= r_mem[i_addr_b];
            r_mem[i_addr_a] <= i_wdata;
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

### sv/cpcf_peak_clamp.sv
// ----------------------------------------------------------------------------
// cpcf_peak_clamp
// clamps a strict local peak to its largest existing neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module cpcf_peak_clamp (
    input  wire cpcf_pkg::t_window i_win,
    output cpcf_pkg::t_pix         o_value
);

    cpcf_pkg::t_pix nb [4];
    cpcf_pkg::t_pix max_nb;
    logic           peak;

    always_comb begin
        nb[cpcf_pkg::NB_UP]    = i_win.up;
        nb[cpcf_pkg::NB_DOWN]  = i_win.down;
        nb[cpcf_pkg::NB_LEFT]  = i_win.left;
        nb[cpcf_pkg::NB_RIGHT] = i_win.right;
        max_nb = '0;
        peak   = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (i_win.has[k]) begin
                if (nb[k] >= i_win.me) begin
                    peak = 1'b0;
                end
                if (nb[k] > max_nb) begin
                    max_nb = nb[k];
                end
            end
        end
        // no neighbors at all leaves peak set and max at zero
        o_value = peak ? max_nb : i_win.me;
    end

endmodule

`default_nettype wire

### sv/cross_peak_clamp_filter_unit.sv
// ----------------------------------------------------------------------------
// cross_peak_clamp_filter_unit
// four-neighbor local peak clamp over a raster-order pixel stream
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall carry one pixel word per accepted cycle,
//   frames in raster order. output channel: o_valid / i_stall carry result
//   words with row, column, clamped value, run_last and frame_done.
//   config channel: i_cfg_valid / o_cfg_ready (always ready) write
//   frame_width (index 0) or frame_height (index 1); any write restarts the
//   frame at row 0, column 0. write only while the block is idle.
// pipeline and throughput
//   a result word goes through stage 1 and then the output register after its
//   pixel is accepted; results trail the input by one row, and the last row
//   is emitted as the right neighbors arrive. one pixel per cycle while each
//   pixel causes at most one result and the output is not stalled; on the
//   last row a pixel can cause two results (three at its end), and the single
//   output register paces the input to one result word per cycle.
// reset
//   synchronous active low: counters, pipeline valids and window registers
//   clear, frame size returns to 1024 x 1024. the line store is not cleared;
//   only rows of the current frame are ever read.
// stall
//   a stalled output word holds, and a stage-1 word with a result to emit
//   holds behind it with o_stall high at once; nothing is lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module cross_peak_clamp_filter_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // pixel input
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [cpcf_pkg::PIX_W-1:0]       i_pixel_in,
    // result output
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [cpcf_pkg::ROW_W-1:0]            o_out_row,
    output logic [cpcf_pkg::COL_W-1:0]            o_out_col,
    output logic [cpcf_pkg::PIX_W-1:0]            o_out_value,
    output logic                                  o_run_last,
    output logic                                  o_frame_done,
    // configuration write
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [cpcf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [cpcf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // pending result kinds of the item in stage 1, emitted lowest bit first
    localparam int KIND_ABOVE = 0;  // pixel one row above the input
    localparam int KIND_LEFT  = 1;  // last row, pixel left of the input
    localparam int KIND_SELF  = 2;  // last row, last column, the input itself

    // frame geometry, kept as last column / last row
    logic [cpcf_pkg::COL_W-1:0] r_w_last, n_w_last;
    logic [cpcf_pkg::ROW_W-1:0] r_h_last, n_h_last;
    logic [cpcf_pkg::WIDTH_REG_W-1:0] cfg_width;

    // position of the next input pixel
    logic [cpcf_pkg::COL_W-1:0] r_col, n_col;
    logic [cpcf_pkg::ROW_W-1:0] r_row, n_row;

    // first pixel of the most recent row
    cpcf_pkg::t_pix r_first;

    // stage 1: accepted pixel with its position flags
    logic                       r_s1_valid, n_s1_valid;
    logic [2:0]                 r_pend, n_pend;
    cpcf_pkg::t_pix             r_s1_px;
    cpcf_pkg::t_pix             r_s1_first;
    logic [cpcf_pkg::ROW_W-1:0] r_s1_row;
    logic [cpcf_pkg::COL_W-1:0] r_s1_col;
    logic                       r_s1_col0;
    logic                       r_s1_col_ge2;
    logic                       r_s1_row_ge1;
    logic                       r_s1_row_ge2;
    logic                       r_s1_has_right;

    // sliding windows: row above (me, right) and current row (two back)
    cpcf_pkg::t_pix r_win_me;
    cpcf_pkg::t_pix r_win_right;
    cpcf_pkg::t_pix r_cur1;
    cpcf_pkg::t_pix r_cur2;

    // output register
    logic                       r_out_valid, n_out_valid;
    logic [cpcf_pkg::ROW_W-1:0] r_out_row;
    logic [cpcf_pkg::COL_W-1:0] r_out_col;
    cpcf_pkg::t_pix             r_out_value;
    logic                       r_out_run_last;
    logic                       r_out_frame_done;

    // handshake and sequencing
    logic accept;
    logic cfg_write;
    logic out_free;
    logic emit;
    logic retire;
    logic [2:0] cur_sel;
    logic [2:0] rest;

    // line store read data: row two back (up) and row above, one column ahead
    cpcf_pkg::t_pix rd_up;
    cpcf_pkg::t_pix rd_right;

    cpcf_pkg::t_pix    me_above;
    cpcf_pkg::t_window win_sel;
    cpcf_pkg::t_pix    clamp_value;
    logic [cpcf_pkg::ROW_W-1:0] res_row;
    logic [cpcf_pkg::COL_W-1:0] res_col;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;

    assign cur_sel  = r_pend & (~r_pend + 3'd1);
    assign rest     = r_pend & ~cur_sel;
    assign out_free = ~r_out_valid | ~i_stall;
    assign emit     = r_s1_valid & (r_pend != 3'd0) & out_free;
    assign retire   = r_s1_valid & ((r_pend == 3'd0) | (emit & (rest == 3'd0)));
    assign o_stall  = r_s1_valid & ~retire;
    assign accept   = i_valid & ~o_stall;

    // ------------------------------------------------------------------------
    // line store: write the input at its row parity, read the same entry
    // (row two back) and the row above one column ahead
    // ------------------------------------------------------------------------
    cpcf_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_en      (accept),
        .i_addr_a  ({r_row[0], r_col}),
        .i_wdata   (i_pixel_in),
        .i_addr_b  ({~r_row[0], r_col + 1'b1}),
        .o_rdata_a (rd_up),
        .o_rdata_b (rd_right)
    );

    // ------------------------------------------------------------------------
    // configuration: effective geometry worked out at write time
    // ------------------------------------------------------------------------
    assign cfg_width = i_cfg_data[cpcf_pkg::WIDTH_REG_W-1:0];

    always_comb begin
        n_w_last = r_w_last;
        n_h_last = r_h_last;
        if (cfg_write) begin
            unique case (i_cfg_index)
                cpcf_pkg::CFG_FRAME_WIDTH: begin
                    if (cfg_width == '0) begin
                        n_w_last = '0;
                    end else if (cfg_width >
                                 cpcf_pkg::WIDTH_REG_W'(cpcf_pkg::MAX_WIDTH)) begin
                        n_w_last = cpcf_pkg::COL_W'(cpcf_pkg::MAX_WIDTH - 1);
                    end else begin
                        n_w_last = cpcf_pkg::COL_W'(cfg_width - 1'b1);
                    end
                end
                cpcf_pkg::CFG_FRAME_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        n_h_last = '0;
                    end else begin
                        n_h_last = cpcf_pkg::ROW_W'(i_cfg_data - 1'b1);
                    end
                end
                default: begin
                    n_w_last = r_w_last;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // input position counters
    // ------------------------------------------------------------------------
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_write) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (r_col == r_w_last) begin
                n_col = '0;
                n_row = (r_row == r_h_last) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 1 control
    // ------------------------------------------------------------------------
    always_comb begin
        n_s1_valid = r_s1_valid;
        n_pend     = r_pend;
        if (retire) begin
            n_s1_valid = 1'b0;
        end
        if (emit) begin
            n_pend = rest;
        end
        if (accept) begin
            n_s1_valid             = 1'b1;
            n_pend[KIND_ABOVE]     = (r_row != '0);
            n_pend[KIND_LEFT]      = (r_row == r_h_last) & (r_col != '0);
            n_pend[KIND_SELF]      = (r_row == r_h_last) & (r_col == r_w_last);
        end
    end

    // ------------------------------------------------------------------------
    // window for the selected result
    // ------------------------------------------------------------------------
    assign me_above = r_s1_col0 ? r_s1_first : r_win_right;

    always_comb begin
        win_sel = '0;
        res_row = r_s1_row;
        res_col = r_s1_col;
        priority if (cur_sel[KIND_ABOVE]) begin
            // pixel above the input: the input itself is its down neighbor
            win_sel.me    = me_above;
            win_sel.up    = rd_up;
            win_sel.down  = r_s1_px;
            win_sel.left  = r_win_me;
            win_sel.right = rd_right;
            win_sel.has[cpcf_pkg::NB_UP]    = r_s1_row_ge2;
            win_sel.has[cpcf_pkg::NB_DOWN]  = 1'b1;
            win_sel.has[cpcf_pkg::NB_LEFT]  = ~r_s1_col0;
            win_sel.has[cpcf_pkg::NB_RIGHT] = r_s1_has_right;
            res_row = r_s1_row - 1'b1;
        end else if (cur_sel[KIND_LEFT]) begin
            // last row, previous pixel: the input is its right neighbor
            win_sel.me    = r_cur1;
            win_sel.up    = r_win_me;
            win_sel.left  = r_cur2;
            win_sel.right = r_s1_px;
            win_sel.has[cpcf_pkg::NB_UP]    = r_s1_row_ge1;
            win_sel.has[cpcf_pkg::NB_LEFT]  = r_s1_col_ge2;
            win_sel.has[cpcf_pkg::NB_RIGHT] = 1'b1;
            res_col = r_s1_col - 1'b1;
        end else begin
            // final pixel of the frame
            win_sel.me    = r_s1_px;
            win_sel.up    = me_above;
            win_sel.left  = r_cur1;
            win_sel.has[cpcf_pkg::NB_UP]    = r_s1_row_ge1;
            win_sel.has[cpcf_pkg::NB_LEFT]  = ~r_s1_col0;
        end
    end

    cpcf_peak_clamp u_peak_clamp (
        .i_win   (win_sel),
        .o_value (clamp_value)
    );

    // ------------------------------------------------------------------------
    // output register control
    // ------------------------------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (~i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last    <= cpcf_pkg::COL_W'(cpcf_pkg::MAX_WIDTH - 1);
            r_h_last    <= cpcf_pkg::ROW_W'(1023);
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            r_win_me    <= '0;
            r_win_right <= '0;
            r_cur1      <= '0;
            r_cur2      <= '0;
        end else begin
            r_w_last    <= n_w_last;
            r_h_last    <= n_h_last;
            r_col       <= n_col;
            r_row       <= n_row;
            r_s1_valid  <= n_s1_valid;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            // windows slide one column as each item leaves stage 1
            if (retire) begin
                r_win_me    <= me_above;
                r_win_right <= rd_right;
                r_cur1      <= r_s1_px;
                r_cur2      <= r_cur1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px        <= i_pixel_in;
            r_s1_first     <= r_first;
            r_s1_row       <= r_row;
            r_s1_col       <= r_col;
            r_s1_col0      <= (r_col == '0);
            r_s1_col_ge2   <= (r_col[cpcf_pkg::COL_W-1:1] != '0);
            r_s1_row_ge1   <= (r_row != '0);
            r_s1_row_ge2   <= (r_row[cpcf_pkg::ROW_W-1:1] != '0);
            r_s1_has_right <= (r_col != r_w_last);
            if (r_col == '0) begin
                r_first <= i_pixel_in;
            end
        end
        if (emit) begin
            r_out_row        <= res_row;
            r_out_col        <= res_col;
            r_out_value      <= clamp_value;
            r_out_run_last   <= (rest == 3'd0);
            r_out_frame_done <= cur_sel[KIND_SELF];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_out_value  = r_out_value;
    assign o_run_last   = r_out_run_last;
    assign o_frame_done = r_out_frame_done;

endmodule

`default_nettype wire

### bench/tb_cross_peak_clamp_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_cross_peak_clamp_filter_unit
// self-checking bench for the four-neighbor peak clamp filter: a behavioral
// predictor tracks frame position and the last two rows, builds the expected
// result words for every accepted pixel, and a monitor compares each output
// word against the oldest prediction while both channels idle and stall
// at random
// ----------------------------------------------------------------------------

module tb_cross_peak_clamp_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cpcf_pkg::*;

    // run sizing
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam int unsigned RANDOM_PIXELS = 85;

    // one predicted result word, same field order as the output ports
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        t_pix             value;
        logic             run_last;
        logic             frame_done;
    } t_clamp_word;

    // ------------------------------------------------------------------------
    // clock, block inputs and the block itself
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic [PIX_W-1:0]      i_pixel_in  = '0;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                  o_stall;
    logic                  o_valid;
    logic [ROW_W-1:0]      o_out_row;
    logic [COL_W-1:0]      o_out_col;
    logic [PIX_W-1:0]      o_out_value;
    logic                  o_run_last;
    logic                  o_frame_done;
    logic                  o_cfg_ready;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    cross_peak_clamp_filter_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel_in   (i_pixel_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_out_value  (o_out_value),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_clamp_word pending_clamps [$];   // predicted words not yet seen

    // predictor's own copy of the block state
    t_pix                   pix_rows [0:MEM_DEPTH-1];   // two rows, one per row parity
    int unsigned            cur_col;
    int unsigned            cur_row;
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [ROW_W-1:0]       height_reg;

    // idling knobs, flipped per phase so quiet stretches happen too
    bit idle_on  = 1'b0;
    bit stall_on = 1'b0;

    int unsigned stall_left    = 0;
    int unsigned cycle_count   = 0;
    int unsigned pixels_sent   = 0;
    int unsigned words_checked = 0;
    int unsigned frames_closed = 0;
    int unsigned mismatches    = 0;

    // mostly short gaps, now and then a long one
    function automatic int unsigned rand_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // out-of-range sizes fold back into the legal range
    function automatic int unsigned eff_w();
        if (width_reg == '0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_h();
        return (height_reg == '0) ? 1 : height_reg;
    endfunction

    // the arriving pixel is not in the row store yet
    function automatic t_pix pix_at(int unsigned r, int unsigned c, t_pix px);
        if (r == cur_row && c == cur_col) return px;
        return pix_rows[(r % 2) * MAX_WIDTH + c];
    endfunction

    // strict peak over the existing neighbors drops to their maximum,
    // a lone pixel drops to zero, everything else passes
    function automatic t_pix clamp_at(int unsigned r, int unsigned c, int unsigned h,
                                      int unsigned w, t_pix px);
        t_pix me;
        t_pix top;
        t_pix nb [4];
        bit   has [4];
        bit   peak;
        me = pix_at(r, c, px);
        has[NB_UP]    = (r > 0);
        has[NB_DOWN]  = (r + 1 < h);
        has[NB_LEFT]  = (c > 0);
        has[NB_RIGHT] = (c + 1 < w);
        nb[NB_UP]     = has[NB_UP]    ? pix_at(r - 1, c, px) : '0;
        nb[NB_DOWN]   = has[NB_DOWN]  ? pix_at(r + 1, c, px) : '0;
        nb[NB_LEFT]   = has[NB_LEFT]  ? pix_at(r, c - 1, px) : '0;
        nb[NB_RIGHT]  = has[NB_RIGHT] ? pix_at(r, c + 1, px) : '0;
        peak = 1'b1;
        top  = '0;
        for (int k = 0; k < 4; k++) begin
            if (has[k]) begin
                if (nb[k] >= me) peak = 1'b0;
                if (nb[k] > top) top = nb[k];
            end
        end
        return peak ? top : me;
    endfunction

    // queue up every word one accepted pixel releases, then advance
    function automatic void predict_clamp_words(t_pix px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned n;
        t_clamp_word words [3];
        w = eff_w();
        h = eff_h();
        if (cur_col >= w) cur_col = 0;
        if (cur_row >= h) cur_row = 0;
        r = cur_row;
        c = cur_col;
        n = 0;
        // pixel one row up is now complete
        if (r >= 1) begin
            words[n] = '0;
            words[n].row   = ROW_W'(r - 1);
            words[n].col   = COL_W'(c);
            words[n].value = clamp_at(r - 1, c, h, w, px);
            n++;
        end
        // bottom row has no row below, so it goes out as right neighbors arrive
        if (r == h - 1) begin
            if (c >= 1) begin
                words[n] = '0;
                words[n].row   = ROW_W'(r);
                words[n].col   = COL_W'(c - 1);
                words[n].value = clamp_at(r, c - 1, h, w, px);
                n++;
            end
            if (c == w - 1) begin
                words[n] = '0;
                words[n].row        = ROW_W'(r);
                words[n].col        = COL_W'(c);
                words[n].value      = clamp_at(r, c, h, w, px);
                words[n].frame_done = 1'b1;
                n++;
            end
        end
        if (n > 0) words[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++) pending_clamps.push_back(words[i]);
        pix_rows[(r % 2) * MAX_WIDTH + c] = px;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        cur_col = c;
        cur_row = r;
    endfunction

    // ------------------------------------------------------------------------
    // output side: random stall and word checker
    // ------------------------------------------------------------------------

    // stall and free stretches alternate, each of random length
    always @(negedge i_clk) begin
        if (!stall_on) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if (i_stall) begin
            i_stall <= 1'b0;
            stall_left = rand_gap();
        end else begin
            i_stall <= 1'b1;
            stall_left = rand_gap();
        end
    end

    // a word moves when valid is high and we are not stalling it
    always @(posedge i_clk) begin : check_words
        t_clamp_word got;
        t_clamp_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.row        = o_out_row;
            got.col        = o_out_col;
            got.value      = o_out_value;
            got.run_last   = o_run_last;
            got.frame_done = o_frame_done;
            if (pending_clamps.size() == 0) begin
                mismatches++;
                $display("%0t: expected no word, actual row %0d col %0d value %0d", $time,
                         got.row, got.col, got.value);
            end else begin
                want = pending_clamps.pop_front();
                words_checked++;
                if (got.frame_done === 1'b1) frames_closed++;
                if (got !== want) begin
                    mismatches++;
                    if (got.row !== want.row)
                        $display("%0t: row expected %0d actual %0d", $time,
                                 want.row, got.row);
                    if (got.col !== want.col)
                        $display("%0t: col expected %0d actual %0d", $time,
                                 want.col, got.col);
                    if (got.value !== want.value)
                        $display("%0t: value at (%0d,%0d) expected %0d actual %0d",
                                 $time, want.row, want.col, want.value, got.value);
                    if (got.run_last !== want.run_last)
                        $display("%0t: run_last expected %0b actual %0b", $time,
                                 want.run_last, got.run_last);
                    if (got.frame_done !== want.frame_done)
                        $display("%0t: frame_done expected %0b actual %0b", $time,
                                 want.frame_done, got.frame_done);
                end
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time,
                     pending_clamps.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // present one pixel word, hold it through stall, predict on acceptance
    task automatic send_pixel(t_pix px);
        int unsigned n;
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_pixel_in <= px;
        do @(posedge i_clk); while (o_stall);
        predict_clamp_words(px);
        pixels_sent++;
        n = idle_on ? rand_gap() : 0;
        if (n > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_pixels(t_pix list [$]);
        foreach (list[i]) send_pixel(list[i]);
    endtask

    // drop valid, let every predicted word come out, then let the pipe settle
    // since trailing pixels may still be in flight without any result
    task automatic wait_for_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_clamps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write, only ever with the block drained
    task automatic write_frame_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_for_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_FRAME_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
        else                        height_reg = data;
        // any write restarts the frame
        cur_col = 0;
        cur_row = 0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(logic [CFG_DATA_W-1:0] w_data, logic [CFG_DATA_W-1:0] h_data);
        write_frame_reg(CFG_FRAME_WIDTH, w_data);
        write_frame_reg(CFG_FRAME_HEIGHT, h_data);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset size is 1024 x 1024: the head of the first row releases nothing,
    // with both pixel extremes at the front of the frame
    task automatic test_reset_frame_size();
        idle_on  = 1'b1;
        stall_on = 1'b1;
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        repeat (6) send_pixel(t_pix'($urandom));
    endtask

    task automatic test_directed_cases();
        idle_on  = 1'b0;
        stall_on = 1'b0;
        // lone pixel frames, each pixel wraps into a new frame
        set_frame(16'd1, 16'd1);
        send_pixels('{16'hFFFF, 16'h0000});
        // zero sizes act as one; upper data bits beyond the width field drop
        set_frame(16'hF800, 16'h0000);
        send_pixel(16'h1234);
        // 3x3: corner peak, tie with a neighbor, max value peak, zeros
        idle_on  = 1'b1;
        stall_on = 1'b1;
        set_frame(16'd3, 16'd3);
        send_pixels('{16'hFFFF, 16'd7, 16'd7,
                      16'd0, 16'd9, 16'd9,
                      16'hFFFF, 16'hFFFE, 16'd0});
        // single column: up and down only
        set_frame(16'd1, 16'd3);
        send_pixels('{16'd5, 16'd3, 16'd5});
        // single row: left and right only, equal neighbors do not clamp
        set_frame(16'd4, 16'd1);
        send_pixels('{16'd0, 16'hFFFF, 16'hFFFF, 16'd1});
        // tallest frame, only its first rows are visited
        set_frame(16'd2, 16'hFFFF);
        send_pixels('{16'd8, 16'd2, 16'd1, 16'd9});
    endtask

    // width field at its top folds to the widest row; one row frame, so
    // every pixel but the first at the head of that row releases its left neighbor
    task automatic test_widest_row();
        idle_on  = 1'b1;
        stall_on = 1'b1;
        set_frame(16'h07FF, 16'h0000);
        repeat (16) send_pixel(t_pix'($urandom));
    endtask

    // explicit mid-frame pause until the output side has caught up
    task automatic test_drain_pause();
        idle_on  = 1'b1;
        stall_on = 1'b1;
        set_frame(16'd5, 16'd4);
        repeat (12) send_pixel(t_pix'($urandom_range(0, 7)));
        wait_for_idle();
        repeat (8) send_pixel(t_pix'($urandom_range(0, 7)));
    endtask

    // random small frames: mostly whole frames, some cut short, pixel
    // ranges narrow enough for ties or wide enough to hit every bit
    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned style;
        int unsigned sent;
        logic [CFG_DATA_W-1:0] w_data;
        t_pix px;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            w = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 16);
            h = $urandom_range(1, 4);
            w_data = CFG_DATA_W'($urandom);
            w_data[WIDTH_REG_W-1:0] = WIDTH_REG_W'(w);
            case ($urandom_range(0, 2))
                0: set_frame(w_data, CFG_DATA_W'(h));
                1: begin
                    write_frame_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
                    write_frame_reg(CFG_FRAME_WIDTH, w_data);
                end
                default: write_frame_reg(CFG_FRAME_WIDTH, w_data);
            endcase
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            style    = $urandom_range(0, 2);
            if ($urandom_range(0, 4) != 0) n = eff_w() * eff_h() * $urandom_range(1, 2);
            else                           n = $urandom_range(1, eff_w() * eff_h());
            if (n > RANDOM_PIXELS - sent) n = RANDOM_PIXELS - sent;
            repeat (n) begin
                case (style)
                    0:       px = t_pix'($urandom);
                    1:       px = t_pix'($urandom_range(0, 3));
                    default: px = t_pix'($urandom_range(16'hFFFC, 16'hFFFF));
                endcase
                send_pixel(px);
                sent++;
                // occasional hold-off until everything predicted is out
                if ($urandom_range(0, 39) == 0) wait_for_idle();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < MEM_DEPTH; i++) pix_rows[i] = '0;
        cur_col    = 0;
        cur_row    = 0;
        width_reg  = WIDTH_REG_W'(MAX_WIDTH);
        height_reg = ROW_W'(1024);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_frame_size();
        test_directed_cases();
        test_widest_row();
        test_drain_pause();
        test_random_frames();

        idle_on = 1'b0;
        wait_for_idle();
        stall_on = 1'b0;

        $display("run: %0d pixel words in, %0d result words checked, %0d frames closed",
                 pixels_sent, words_checked, frames_closed);
        $display("sizes from single pixel up to the widest row and tallest frame");
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
